>>> hdl/fgtb_pkg.sv
`default_nettype none

package fgtb_pkg;

    localparam int GROUP = 4;
    localparam int MAX_FLOWS_DEF = 2048;

    localparam int VALUE_W = 16;
    localparam int CLIP_W = 12;
    localparam int SKIP_W = 7;
    localparam int COUNT_W = 10;
    localparam int TLEN_W = 12;
    localparam int CMP_W = 16;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [VALUE_W-1:0] THRESHOLD_RST = 16'd50;
    localparam logic [VALUE_W-1:0] CEILING_RST = 16'd69;
    localparam logic [SKIP_W-1:0] SKIP_RST = 7'd8;

    // rounding: (v + 50) / 100 as (v + 50) * ceil(2^23 / 100) >> 23
    localparam logic [VALUE_W:0] ROUND_BIAS = 17'd50;
    localparam logic [VALUE_W:0] RECIP_100 = 17'd83887;
    localparam int RECIP_SHIFT = 23;

    localparam logic [TLEN_W-1:0] TLEN_MAX = 12'hFFF;

    localparam logic [1:0] REG_SIGNAL_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_NOISE_CEILING = 2'd1;
    localparam logic [1:0] REG_SKIP_FLOWS = 2'd2;

    localparam logic KIND_RUN = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [VALUE_W-1:0] flow_value;
        logic [CLIP_W-1:0]  clip_flows;
        logic               last_flow;
    } flow_beat_t;

    typedef struct packed {
        logic               kind;
        logic [1:0]         base_code;
        logic [COUNT_W-1:0] run_count;
        logic [TLEN_W-1:0]  trimmed_length;
        logic               last;
    } result_beat_t;

    typedef struct packed {
        logic [VALUE_W-1:0] signal_threshold;
        logic [VALUE_W-1:0] noise_ceiling;
        logic [SKIP_W-1:0]  skip_flows;
    } cfg_t;

    typedef struct packed {
        logic                          load;
        logic [GROUP-1:0]              run_mask;
        logic [GROUP-1:0][COUNT_W-1:0] counts;
        logic                          summary;
        logic [TLEN_W-1:0]             tlen;
    } job_t;

endpackage

`default_nettype wire

>>> hdl/fgtb_cfg.sv
`default_nettype none

module fgtb_cfg
    import fgtb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    cfg_t        cfg_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.signal_threshold <= THRESHOLD_RST;
            cfg_reg.noise_ceiling <= CEILING_RST;
            cfg_reg.skip_flows <= SKIP_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_SIGNAL_THRESHOLD: cfg_reg.signal_threshold <= pwdata[VALUE_W-1:0];
                REG_NOISE_CEILING:    cfg_reg.noise_ceiling <= pwdata[VALUE_W-1:0];
                REG_SKIP_FLOWS:       cfg_reg.skip_flows <= pwdata[SKIP_W-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SIGNAL_THRESHOLD: prdata = {{(PDATA_W-VALUE_W){1'b0}}, cfg_reg.signal_threshold};
            REG_NOISE_CEILING:    prdata = {{(PDATA_W-VALUE_W){1'b0}}, cfg_reg.noise_ceiling};
            REG_SKIP_FLOWS:       prdata = {{(PDATA_W-SKIP_W){1'b0}}, cfg_reg.skip_flows};
            default:              prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/fgtb_screen.sv
`default_nettype none

module fgtb_screen
    import fgtb_pkg::*;
#(
    parameter int MAX_FLOWS = MAX_FLOWS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  wire flow_beat_t beat,
    input  wire cfg_t       cfg,
    output job_t            job
);

    localparam int POS_W = $clog2(MAX_FLOWS + 1);
    localparam int KG_W = $clog2(MAX_FLOWS / GROUP + 1);

    typedef struct packed {
        logic               sig;
        logic               noise;
        logic [COUNT_W-1:0] cnt;
    } flow_info_t;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [KG_W-1:0]  kept_reg;
    logic [KG_W-1:0]  kept_next;
    logic             stopped_reg;
    logic             stopped_next;
    flow_info_t       buf_reg [GROUP];

    logic [VALUE_W:0]     biased;
    logic [2*VALUE_W+1:0] prod;
    flow_info_t           info_now;
    flow_info_t [GROUP-1:0] grp;
    logic                 active;
    logic                 group_done;
    logic [POS_W-1:0]     start;
    logic                 clip_hit;
    logic                 any_sig;
    logic                 any_noise;
    logic                 keep;
    logic [POS_W-1:0]     idx [GROUP];
    logic [GROUP-1:0]     run_mask;
    logic [KG_W+1:0]      tlen_wide;

    assign biased = {1'b0, beat.flow_value} + ROUND_BIAS;
    assign prod = {{(VALUE_W+1){1'b0}}, biased} * {{(VALUE_W+1){1'b0}}, RECIP_100};

    always_comb
    begin
        info_now.sig = beat.flow_value > cfg.signal_threshold;
        info_now.noise = info_now.sig && (beat.flow_value <= cfg.noise_ceiling);
        info_now.cnt = prod[RECIP_SHIFT+COUNT_W-1:RECIP_SHIFT];
    end

    assign active = pos_reg != POS_W'(MAX_FLOWS);
    assign group_done = active && (pos_reg[1:0] == 2'd3) && !stopped_reg;
    assign start = {pos_reg[POS_W-1:2], 2'b00};
    assign clip_hit = {{(CMP_W-POS_W){1'b0}}, start} >= {{(CMP_W-CLIP_W){1'b0}}, beat.clip_flows};

    always_comb
    begin
        for (int k = 0; k < GROUP - 1; k++)
        begin
            grp[k] = buf_reg[k];
        end
        grp[GROUP-1] = info_now;
        any_sig = 1'b0;
        any_noise = 1'b0;
        for (int k = 0; k < GROUP; k++)
        begin
            any_sig = any_sig | grp[k].sig;
            any_noise = any_noise | grp[k].noise;
        end
    end

    assign keep = group_done && !clip_hit && any_sig && !any_noise;

    always_comb
    begin
        for (int k = 0; k < GROUP; k++)
        begin
            idx[k] = {pos_reg[POS_W-1:2], 2'(k)};
            run_mask[k] = keep && (grp[k].cnt != '0)
                && ({{(CMP_W-POS_W){1'b0}}, idx[k]} >= {{(CMP_W-SKIP_W){1'b0}}, cfg.skip_flows});
        end
    end

    assign kept_next = kept_reg + KG_W'(keep);
    assign tlen_wide = {kept_next, 2'b00};

    always_comb
    begin
        job.load = fire && ((|run_mask) || beat.last_flow);
        job.run_mask = run_mask;
        for (int k = 0; k < GROUP; k++)
        begin
            job.counts[k] = grp[k].cnt;
        end
        job.summary = beat.last_flow;
        if ({{(CMP_W-KG_W-2){1'b0}}, tlen_wide} > {{(CMP_W-TLEN_W){1'b0}}, TLEN_MAX})
        begin
            job.tlen = TLEN_MAX;
        end
        else
        begin
            job.tlen = TLEN_W'(tlen_wide);
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        stopped_next = stopped_reg;
        if (active)
        begin
            pos_next = pos_reg + 1'b1;
            if (group_done && !keep)
            begin
                stopped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            kept_reg <= '0;
            stopped_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (beat.last_flow)
            begin
                pos_reg <= '0;
                kept_reg <= '0;
                stopped_reg <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_next;
                kept_reg <= kept_next;
                stopped_reg <= stopped_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && active)
        begin
            buf_reg[pos_reg[1:0]] <= info_now;
        end
    end

endmodule

`default_nettype wire

>>> hdl/fgtb_emit.sv
`default_nettype none

module fgtb_emit
    import fgtb_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire job_t   job,
    output logic        take,
    output logic        res_valid,
    input  wire logic   res_ready,
    output result_beat_t res
);

    logic [GROUP-1:0]              mask_reg;
    logic                          sum_reg;
    logic [GROUP-1:0][COUNT_W-1:0] counts_reg;
    logic [TLEN_W-1:0]             tlen_reg;

    logic [1:0]       sel;
    logic [GROUP-1:0] mask_rest;
    logic             pop;

    always_comb
    begin
        sel = 2'd0;
        for (int k = GROUP - 1; k >= 0; k--)
        begin
            if (mask_reg[k])
            begin
                sel = 2'(k);
            end
        end
    end

    assign mask_rest = mask_reg & (mask_reg - 1'b1);
    assign res_valid = (|mask_reg) || sum_reg;
    assign pop = res_valid && res_ready;
    assign take = !res_valid || (res_ready && res.last);

    always_comb
    begin
        if (|mask_reg)
        begin
            res.kind = KIND_RUN;
            res.base_code = sel;
            res.run_count = counts_reg[sel];
            res.trimmed_length = '0;
            res.last = (mask_rest == '0) && !sum_reg;
        end
        else
        begin
            res.kind = KIND_SUMMARY;
            res.base_code = '0;
            res.run_count = '0;
            res.trimmed_length = tlen_reg;
            res.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            sum_reg <= 1'b0;
        end
        else if (job.load)
        begin
            mask_reg <= job.run_mask;
            sum_reg <= job.summary;
        end
        else if (pop)
        begin
            if (|mask_reg)
            begin
                mask_reg <= mask_rest;
            end
            else
            begin
                sum_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job.load)
        begin
            counts_reg <= job.counts;
            tlen_reg <= job.tlen;
        end
    end

endmodule

`default_nettype wire

>>> hdl/flowgram_trim_and_base_call_top.sv
// Flowgram trim and base call.
// Flow channel (flow_valid/flow_ready/flow): one beat per flow of a read, with
// the read's clip length and a flag on its final flow. Result channel
// (res_valid/res_ready/res): base runs of kept groups, then one summary with
// the trimmed length on the read's last flow; res.last marks the final result
// of a flow beat.
// Latency: results of a flow appear the cycle after its beat is taken.
// Throughput: with res_ready held high a flow is taken every cycle while each
// flow gives at most one result; a flow giving more results (up to four runs
// plus a summary) holds off the next flow until its final result is taken,
// the result serialiser being the limit.
// When the receiver stalls, pending results hold and flow_ready stays low
// until the final result of the previous flow is taken; in that cycle
// flow_ready follows res_ready.
// Reset clears the read state and loads the default thresholds and skip count.
// The user must set them over the APB port only between reads, unchecked.
`default_nettype none

module flowgram_trim_and_base_call_top
    import fgtb_pkg::*;
#(
    parameter int MAX_FLOWS = MAX_FLOWS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               flow_valid,
    output logic                    flow_ready,
    input  wire flow_beat_t         flow,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output result_beat_t            res,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    cfg_t cfg;
    job_t job;
    logic fire;

    assign fire = flow_valid && flow_ready;

    fgtb_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fgtb_screen #(
        .MAX_FLOWS (MAX_FLOWS)
    ) u_screen
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .beat  (flow),
        .cfg   (cfg),
        .job   (job)
    );

    fgtb_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .take      (flow_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    a_last_gives_summary: assert property (@(posedge clk) disable iff (!rst_n)
        fire && flow.last_flow |=> res_valid)
        else $error("no result after last flow");

    a_accept_only_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_valid |-> res_ready && res.last)
        else $error("flow taken while results pending");

    a_summary_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind == KIND_SUMMARY |-> res.last && res.run_count == '0)
        else $error("summary not final");

    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind == KIND_RUN |-> res.run_count != '0)
        else $error("zero run emitted");

endmodule

`default_nettype wire

>>> tb/sv/fgtb_tb_pkg.sv
package fgtb_tb_pkg;

    import fgtb_pkg::*;

    class base_call_tracker;

        int unsigned sig_thr;
        int unsigned noise_ceil;
        int unsigned skip_count;

        int unsigned flow_idx;
        int unsigned group_vals[GROUP];
        int unsigned kept_groups;
        bit          stopped;

        result_beat_t due_calls[$];
        int unsigned  errors;

        function new();
            sig_thr = THRESHOLD_RST;
            noise_ceil = CEILING_RST;
            skip_count = SKIP_RST;
            flow_idx = 0;
            kept_groups = 0;
            stopped = 1'b0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] v);
            case (idx)
                REG_SIGNAL_THRESHOLD: sig_thr = v[15:0];
                REG_NOISE_CEILING:    noise_ceil = v[15:0];
                REG_SKIP_FLOWS:       skip_count = v[6:0];
                default:              ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [1:0] idx);
            case (idx)
                REG_SIGNAL_THRESHOLD: return sig_thr;
                REG_NOISE_CEILING:    return noise_ceil;
                REG_SKIP_FLOWS:       return skip_count;
                default:              return '0;
            endcase
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // screens a completed group and queues the runs and summary due
        function void note_flow(flow_beat_t f);
            result_beat_t r;
            int unsigned  start;
            int unsigned  cnt;
            int unsigned  sig;
            int unsigned  noise;
            int unsigned  tlen;
            int           k;
            int           first;
            first = due_calls.size();
            if (flow_idx < MAX_FLOWS_DEF)
            begin
                group_vals[flow_idx % GROUP] = f.flow_value;
                flow_idx++;
                if (flow_idx % GROUP == 0 && !stopped)
                begin
                    start = flow_idx - GROUP;
                    if (start >= f.clip_flows)
                    begin
                        stopped = 1'b1;
                    end
                    else
                    begin
                        sig = 0;
                        noise = 0;
                        for (k = 0; k < GROUP; k++)
                        begin
                            if (group_vals[k] > sig_thr)
                            begin
                                sig++;
                                if (group_vals[k] <= noise_ceil)
                                    noise++;
                            end
                        end
                        if (noise != 0 || sig == 0)
                        begin
                            stopped = 1'b1;
                        end
                        else
                        begin
                            kept_groups++;
                            for (k = 0; k < GROUP; k++)
                            begin
                                cnt = (group_vals[k] + 50) / 100;
                                if (start + k >= skip_count && cnt != 0)
                                begin
                                    r = '0;
                                    r.kind = KIND_RUN;
                                    r.base_code = 2'(k);
                                    r.run_count = COUNT_W'(cnt);
                                    due_calls.insert(due_calls.size(), r);
                                end
                            end
                        end
                    end
                end
            end
            if (f.last_flow)
            begin
                tlen = kept_groups * GROUP;
                if (tlen > TLEN_MAX)
                    tlen = TLEN_MAX;
                r = '0;
                r.kind = KIND_SUMMARY;
                r.trimmed_length = TLEN_W'(tlen);
                due_calls.insert(due_calls.size(), r);
                flow_idx = 0;
                kept_groups = 0;
                stopped = 1'b0;
            end
            if (due_calls.size() > first)
                due_calls[due_calls.size() - 1].last = 1'b1;
        endfunction

        function void check_call(result_beat_t r);
            result_beat_t e;
            if (due_calls.size() == 0)
            begin
                $error("result beat with nothing due: kind %0d count %0d length %0d",
                       r.kind, r.run_count, r.trimmed_length);
                errors++;
                return;
            end
            e = due_calls.pop_front();
            check_field("kind", e.kind, r.kind);
            check_field("base_code", e.base_code, r.base_code);
            check_field("run_count", e.run_count, r.run_count);
            check_field("trimmed_length", e.trimmed_length, r.trimmed_length);
            check_field("last", e.last, r.last);
        endfunction

    endclass

endpackage

>>> tb/sv/flowgram_trim_and_base_call_top_test.sv
module flowgram_trim_and_base_call_top_test;

    import fgtb_pkg::*;
    import fgtb_tb_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int RUN_LIMIT = 800000;
    localparam int PHASE_FLOWS = 26;

    logic               clk;
    logic               rst_n;
    logic               flow_valid;
    logic               flow_ready;
    flow_beat_t         flow;
    logic               res_valid;
    logic               res_ready;
    result_beat_t       res;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    base_call_tracker read_calls;
    bit               no_gaps;
    int unsigned      sent_flows;
    int               cycle_count;

    flowgram_trim_and_base_call_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .flow_valid (flow_valid),
        .flow_ready (flow_ready),
        .flow       (flow),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("flowgram_trim_and_base_call_top verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && res_valid === 1'b1 && res_ready === 1'b1)
            read_calls.check_call(res);
    end

    // result side: random stall before each beat
    initial
    begin
        int unsigned stall;
        res_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                @(negedge clk) res_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            if (stall > 0 || res_ready == 1'b0)
                @(negedge clk) res_ready <= 1'b1;
            @(posedge clk);
            while (res_valid !== 1'b1)
                @(posedge clk);
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] v);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= v;
        @(negedge clk) penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        read_calls.set_reg(idx, v);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic reg_read(input logic [1:0] idx);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= PADDR_W'({idx, 2'b00});
        @(negedge clk) penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        read_calls.check_field("prdata", read_calls.reg_value(idx), prdata);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_flow(input flow_beat_t b);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            @(negedge clk) flow_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        flow_valid <= 1'b1;
        flow <= b;
        @(posedge clk);
        while (!flow_ready)
            @(posedge clk);
        read_calls.note_flow(b);
    endtask

    task automatic send_read(input int unsigned vals[$], input int unsigned clip);
        flow_beat_t b;
        for (int i = 0; i < vals.size(); i++)
        begin
            b.flow_value = vals[i][15:0];
            b.clip_flows = clip[11:0];
            b.last_flow = (i == vals.size() - 1);
            send_flow(b);
        end
        @(negedge clk) flow_valid <= 1'b0;
    endtask

    task automatic wait_results();
        while (read_calls.due_calls.size() != 0)
            @(posedge clk);
    endtask

    // a flow with no result may still be in flight when the queue empties
    task automatic drain();
        wait_results();
        repeat (4) @(posedge clk);
    endtask

    function automatic int unsigned good_value();
        int unsigned lo;
        lo = ((read_calls.sig_thr > read_calls.noise_ceil) ?
              read_calls.sig_thr : read_calls.noise_ceil) + 1;
        if (lo > 65535)
            return $urandom_range(0, 65535);
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(lo, 65535);
        return $urandom_range(lo, (lo + 999 > 65535) ? 65535 : lo + 999);
    endfunction

    function automatic int unsigned quiet_value();
        return $urandom_range(0, read_calls.sig_thr);
    endfunction

    function automatic int unsigned noise_value();
        if (read_calls.sig_thr < read_calls.noise_ceil)
            return $urandom_range(read_calls.sig_thr + 1, read_calls.noise_ceil);
        return $urandom_range(0, 65535);
    endfunction

    // mostly well-formed groups; some with a noise flow, some raw
    task automatic random_read();
        int unsigned vals[$];
        int unsigned groups;
        int unsigned extra;
        int unsigned mode;
        int unsigned forced;
        int unsigned clip;
        int unsigned sel;
        int unsigned v;
        groups = $urandom_range(1, 6);
        extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        for (int g = 0; g < groups; g++)
        begin
            mode = $urandom_range(0, 9);
            forced = $urandom_range(0, 3);
            for (int k = 0; k < GROUP; k++)
            begin
                if (mode == 0)
                    v = (k == forced) ? noise_value() : $urandom_range(0, 65535);
                else if (mode == 1)
                    v = $urandom_range(0, 65535);
                else if (k == forced || $urandom_range(0, 3) != 0)
                    v = good_value();
                else
                    v = quiet_value();
                vals.insert(vals.size(), v);
            end
        end
        for (int e = 0; e < extra; e++)
            vals.insert(vals.size(), good_value());
        sel = $urandom_range(0, 9);
        if (sel < 4)
            clip = MAX_FLOWS_DEF;
        else if (sel < 7)
            clip = $urandom_range(0, vals.size() + 4);
        else
            clip = $urandom_range(0, MAX_FLOWS_DEF);
        no_gaps = ($urandom_range(0, 3) == 0);
        send_read(vals, clip);
        sent_flows += vals.size();
    endtask

    task automatic run_phase(input int unsigned thr, input int unsigned ceil_v,
                             input int unsigned skip, input int unsigned budget);
        int unsigned reads;
        drain();
        reg_write(REG_SIGNAL_THRESHOLD, thr);
        reg_write(REG_NOISE_CEILING, ceil_v);
        reg_write(REG_SKIP_FLOWS, skip);
        reg_write(REG_UNUSED, $urandom);
        reg_read(REG_SIGNAL_THRESHOLD);
        reg_read(REG_NOISE_CEILING);
        reg_read(REG_SKIP_FLOWS);
        sent_flows = 0;
        reads = 0;
        while (sent_flows < budget)
        begin
            random_read();
            reads++;
            if (reads % 3 == 0)
                wait_results();
        end
    endtask

    initial
    begin
        read_calls = new();
        no_gaps = 1'b0;
        flow_valid = 1'b0;
        flow = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        reg_read(REG_SIGNAL_THRESHOLD);
        reg_read(REG_NOISE_CEILING);
        reg_read(REG_SKIP_FLOWS);
        reg_write(REG_SKIP_FLOWS, 0);

        // zero counts dropped, then a group completing on the last flow
        send_read('{0, 65535, 49, 70, 150, 100, 250, 5000}, MAX_FLOWS_DEF);
        // noise flow stops screening; incomplete group at read end
        send_read('{200, 60, 300, 400, 500, 600}, MAX_FLOWS_DEF);
        // group starting at the clip length
        send_read('{120, 80, 300, 250, 400, 500, 600, 700}, 4);
        // single flow read, zero clip
        send_read('{300}, 0);
        // group without any signal
        send_read('{0, 50, 10, 25}, MAX_FLOWS_DEF);

        run_phase(THRESHOLD_RST, CEILING_RST, SKIP_RST, PHASE_FLOWS);
        run_phase(0, 0, 0, PHASE_FLOWS);
        run_phase(65535, 65535, 64, PHASE_FLOWS);
        run_phase($urandom_range(0, 2000), $urandom_range(0, 3000),
                  $urandom_range(0, 64), PHASE_FLOWS);
        run_phase(1000, 65535, $urandom_range(0, 64), PHASE_FLOWS);
        run_phase(200, 100, 4, PHASE_FLOWS);
        drain();

        if (read_calls.errors == 0)
            $display("flowgram_trim_and_base_call_top verification clean");
        else
            $display("flowgram_trim_and_base_call_top verification failed");
        $finish;
    end

endmodule
